FILE: hdl/dht_pkg.sv
// Package for the double-hashing hash table: payload types, status codes and
// reset constants. No dependencies.
`timescale 1ns / 1ps

package dht_pkg;

	localparam int DEPTH_DEFAULT     = 1024;
	localparam int KEY_BYTES_DEFAULT = 8;
	localparam int CFG_W             = 11;
	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1021;
	localparam int SIZE_MIN          = 5;
	localparam int PADDR_W           = 3;
	localparam logic [PADDR_W-1:0] ADDR_TABLE_SIZE = 3'd0;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY_KEY = 3'd4
	} dht_status_t;

	typedef struct packed {
		logic        opcode;
		logic [63:0] key;
		logic [31:0] value;
	} dht_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  slot;
		logic [31:0] found_value;
	} dht_out_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

endpackage

FILE: hdl/dht_fifo.sv
// Two-entry queue between the front and back parts of the hash table.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module dht_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign avail    = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && avail;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: hdl/dht_front.sv
// Front part of the hash table: accepts a transaction, cuts the key, forms the
// byte sum and derives home slot and stride with a bit-serial remainder unit.
// Depends on dht_pkg.
`timescale 1ns / 1ps

module dht_front import dht_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int KEY_BYTES   = KEY_BYTES_DEFAULT,
	localparam int SLOT_W = $clog2(TABLE_DEPTH),
	localparam int N_W    = SLOT_W + 1,
	localparam int KEY_W  = 8 * KEY_BYTES,
	localparam int JOB_W  = 2 + KEY_W + 32 + 2 * SLOT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             hold,
	input  logic [N_W-1:0]   n_used,
	input  logic             in_valid,
	output logic             in_stall,
	input  dht_in_t          in_data,
	output logic             job_push,
	output logic [JOB_W-1:0] job_data,
	input  logic             job_full
);
	localparam int SUM_MAX = 255 * KEY_BYTES * (KEY_BYTES + 1) / 2;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	localparam int CNT_W   = $clog2(SUM_W + 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t          state_q;
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [31:0]      val_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   rm1_q, rm2_q;

	logic [KEY_W-1:0] cut_key;
	logic [SUM_W-1:0] cut_sum;
	logic             alive;
	logic [N_W-1:0]   d2;
	logic [N_W:0]     t1, t2;
	logic             accept;

	// Key is taken as a string: bytes after the first zero are dropped.
	always_comb begin
		cut_key = '0;
		cut_sum = '0;
		alive   = 1'b1;
		for (int b = 0; b < KEY_BYTES; b++) begin
			alive = alive && (in_data.key[8*b +: 8] != 8'd0);
			if (alive) begin
				cut_key[8*b +: 8] = in_data.key[8*b +: 8];
				cut_sum = cut_sum + SUM_W'((b + 1) * int'(in_data.key[8*b +: 8]));
			end
		end
	end

	assign d2     = n_used - N_W'(2);
	assign t1     = {rm1_q, sum_q[SUM_W-1]};
	assign t2     = {rm2_q, sum_q[SUM_W-1]};
	assign in_stall = (state_q != F_IDLE) || hold;
	assign accept = in_valid && !in_stall;
	assign job_push = (state_q == F_PUSH);
	assign job_data = {op_q, (key_q == '0), key_q, val_q,
		SLOT_W'(rm1_q), SLOT_W'(rm2_q + 1'b1)};

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_data.opcode;
			key_q <= cut_key;
			val_q <= in_data.value;
			sum_q <= cut_sum;
			rm1_q <= '0;
			rm2_q <= '0;
		end else if (state_q == F_DIV) begin
			sum_q <= sum_q << 1;
			rm1_q <= (t1 >= {1'b0, n_used}) ? N_W'(t1 - {1'b0, n_used}) : N_W'(t1);
			rm2_q <= (t2 >= {1'b0, d2}) ? N_W'(t2 - {1'b0, d2}) : N_W'(t2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_DIV;
						cnt_q   <= '0;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SUM_W - 1)) state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!job_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/dht_back.sv
// Back part of the hash table: owns the key and value memories, clears the
// key memory after reset, walks the probe path and registers the result.
// Depends on dht_pkg.
`timescale 1ns / 1ps

module dht_back import dht_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int KEY_BYTES   = KEY_BYTES_DEFAULT,
	localparam int SLOT_W = $clog2(TABLE_DEPTH),
	localparam int N_W    = SLOT_W + 1,
	localparam int KEY_W  = 8 * KEY_BYTES,
	localparam int JOB_W  = 2 + KEY_W + 32 + 2 * SLOT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [N_W-1:0]   n_used,
	output logic             clearing,
	input  logic             job_avail,
	input  logic [JOB_W-1:0] job_data,
	output logic             job_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output dht_out_t         out_data
);
	typedef enum logic [4:0] {
		B_CLEAR = 5'b00001,
		B_IDLE  = 5'b00010,
		B_START = 5'b00100,
		B_READ  = 5'b01000,
		B_CMP   = 5'b10000
	} bstate_t;

	bstate_t          state_q;
	logic [SLOT_W-1:0] clr_q, idx_q;
	logic [N_W-1:0]   tries_q;
	logic             op_q, empty_q;
	logic [KEY_W-1:0] key_q;
	logic [31:0]      val_q;
	logic [SLOT_W-1:0] home_q, stride_q;

	logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
	logic [31:0]      val_mem [TABLE_DEPTH];
	logic [KEY_W-1:0] rd_key_q;
	logic [31:0]      rd_val_q;

	logic             out_valid_q;
	dht_out_t         out_q;

	logic             out_free, hit, last_try, emit, mem_we;
	logic [KEY_W-1:0] target;
	logic [N_W:0]     step_sum;
	logic [SLOT_W-1:0] next_idx;
	dht_out_t         res;

	assign clearing  = (state_q == B_CLEAR);
	assign out_free  = !out_valid_q || !out_stall;
	assign job_pop   = (state_q == B_IDLE) && job_avail;
	assign target    = (op_q == OP_INSERT) ? '0 : key_q;
	assign hit       = (rd_key_q == target);
	assign last_try  = (tries_q == n_used - 1'b1);
	assign step_sum  = (N_W+1)'(idx_q) + (N_W+1)'(stride_q);
	assign next_idx  = (step_sum >= (N_W+1)'(n_used)) ?
		SLOT_W'(step_sum - (N_W+1)'(n_used)) : SLOT_W'(step_sum);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		res    = '0;
		emit   = 1'b0;
		mem_we = 1'b0;
		priority if (state_q == B_START && empty_q) begin
			emit       = out_free;
			res.status = ST_EMPTY_KEY;
		end else if (state_q == B_CMP && hit) begin
			emit     = out_free;
			res.slot = 10'(idx_q);
			if (op_q == OP_INSERT) begin
				res.status = ST_INSERTED;
				mem_we     = out_free;
			end else begin
				res.status      = ST_FOUND;
				res.found_value = rd_val_q;
			end
		end else if (state_q == B_CMP && last_try) begin
			emit       = out_free;
			res.status = (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
		end else begin
			emit = 1'b0;
		end
	end

	// Single-port style memories: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (clearing) key_mem[clr_q] <= '0;
		else if (mem_we) key_mem[idx_q] <= key_q;
		if (mem_we) val_mem[idx_q] <= val_q;
		rd_key_q <= key_mem[idx_q];
		rd_val_q <= val_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			{op_q, empty_q, key_q, val_q, home_q, stride_q} <= job_data;
		end
		if (emit) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			tries_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(TABLE_DEPTH - 1)) state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (job_avail) state_q <= B_START;
				end
				B_START: begin
					if (empty_q) begin
						if (emit) state_q <= B_IDLE;
					end else begin
						idx_q   <= home_q;
						tries_q <= '0;
						state_q <= B_READ;
					end
				end
				B_READ: state_q <= B_CMP;
				B_CMP: begin
					if (emit) begin
						state_q <= B_IDLE;
					end else if (!hit && !last_try) begin
						idx_q   <= next_idx;
						tries_q <= tries_q + 1'b1;
						state_q <= B_READ;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !job_pop)
		else $error("queue popped during clearing pass");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ || state_q == B_CMP) |-> (N_W'(idx_q) < n_used))
		else $error("probe index outside table");

	a_tries_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CMP) |-> (tries_q < n_used))
		else $error("probe count exceeds table size");

	a_write_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> out_valid_q)
		else $error("insert written without a result");

endmodule

FILE: hdl/double_hash_table.sv
// Top level of the double-hashing hash table: configuration register, front
// part, queue and back part. Depends on dht_pkg, dht_front, dht_fifo, dht_back.
`timescale 1ns / 1ps

// Usage:
// Transactions enter on in_valid/in_stall/in_data (opcode, key, value) and
// results leave on out_valid/out_stall/out_data (status, slot, found_value);
// a transaction moves at an edge with valid high and stall low.
// The front part cuts the key at its first zero byte, forms the weighted byte
// sum, and derives home slot and stride with a one-bit-per-cycle remainder
// unit. A two-entry queue hands the job to the back part, which takes one job
// at a time and probes the key memory in a read state (address, then
// registered read) and a compare state per probe, after a start state for
// setup. With the front work overlapped, sustained throughput is set by the
// slower of the remainder unit and the probe walk.
// At reset table_size returns to 1021 and the back part sweeps the key memory,
// one slot a cycle; in_stall stays high meanwhile, while the APB register
// stays writable. A stalled receiver holds the result register, which in
// turn holds the back part; the queue then fills and the front part raises
// in_stall.
// table_size is written through the APB port at byte address 0; write it only
// while no transaction is in flight.
module double_hash_table import dht_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	parameter int KEY_BYTES   = KEY_BYTES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  dht_in_t            in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output dht_out_t           out_data
);
	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int N_W    = SLOT_W + 1;
	localparam int KEY_W  = 8 * KEY_BYTES;
	localparam int JOB_W  = 2 + KEY_W + 32 + 2 * SLOT_W;

	logic [CFG_W-1:0] size_q;
	logic [N_W-1:0]   n_used;
	logic             clearing;
	logic             job_push, job_full, job_pop, job_avail;
	logic [JOB_W-1:0] job_in, job_out;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_TABLE_SIZE) ? 32'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_TABLE_SIZE) begin
			size_q <= pwdata[CFG_W-1:0];
		end
	end

	// The slot count in use is the register clamped to the table's limits.
	always_comb begin
		priority if (int'(size_q) < SIZE_MIN) n_used = N_W'(SIZE_MIN);
		else if (int'(size_q) > TABLE_DEPTH) n_used = N_W'(TABLE_DEPTH);
		else n_used = N_W'(size_q);
	end

	dht_front #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BYTES(KEY_BYTES)) u_front (
		.clk, .arst_n,
		.hold     (clearing),
		.n_used,
		.in_valid, .in_stall, .in_data,
		.job_push, .job_data(job_in), .job_full
	);

	dht_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_fifo (
		.clk, .arst_n,
		.push(job_push), .push_data(job_in), .full(job_full),
		.pop(job_pop), .avail(job_avail), .pop_data(job_out)
	);

	dht_back #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BYTES(KEY_BYTES)) u_back (
		.clk, .arst_n,
		.n_used, .clearing,
		.job_avail, .job_data(job_out), .job_pop,
		.out_valid, .out_stall, .out_data
	);

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the double-hashing hash table double_hash_table.
// Depends on dht_pkg and the block's RTL; predicts every result and compares.
`timescale 1ns / 1ps

module testbench;
	import dht_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CYCLE_CAP  = 10000000;
	localparam int DRAIN_WAIT = 64;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	dht_in_t            in_data;
	logic               out_valid;
	logic               out_stall;
	dht_out_t           out_data;

	double_hash_table DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// The predictor keeps its own copy of the table contents and of the size register.
	logic [63:0]      shadow_keys [DEPTH];
	logic [31:0]      shadow_vals [DEPTH];
	logic [CFG_W-1:0] shadow_size;
	dht_out_t         pending_results [$];

	int errors;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;

	// Keys known to be in the table, used to aim finds at real entries.
	logic [63:0] live_keys [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The cycle counter doubles as the timeout watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("mismatch: %s expected %0h got %0h at cycle %0d", what, want, got, cycles);
		errors++;
	endtask

	task automatic check_result(input dht_out_t want, input dht_out_t got);
		if (got.status !== want.status)
			report_mismatch("status", longint'(want.status), longint'(got.status));
		if (got.slot !== want.slot)
			report_mismatch("slot", longint'(want.slot), longint'(got.slot));
		if (got.found_value !== want.found_value)
			report_mismatch("found_value", longint'(want.found_value),
				longint'(got.found_value));
	endtask

	// Receiver: stall at random, and check each accepted result in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", 0, longint'(out_data));
				end else begin
					check_result(pending_results.pop_front(), out_data);
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Cut the key at its first zero byte and form the position-weighted byte sum.
	function automatic logic [63:0] trim_key(input logic [63:0] raw, output int unsigned sum);
		logic [63:0] kept;
		logic [7:0]  b;
		bit          done;
		kept = '0;
		sum  = 0;
		done = 0;
		for (int p = 0; p < 8; p++) begin
			b = raw[8*p +: 8];
			if (b == 8'd0) done = 1;
			if (!done) begin
				kept[8*p +: 8] = b;
				sum += (p + 1) * b;
			end
		end
		return kept;
	endfunction

	// Walk the double-hash probe path looking for target; returns 1 on a hit.
	function automatic bit walk_probe(input logic [63:0] target, input int unsigned sum,
			input int unsigned n, output int unsigned hit);
		int unsigned idx;
		int unsigned stride;
		idx    = sum % n;
		stride = 1 + sum % (n - 2);
		hit    = 0;
		for (int t = 0; t < n; t++) begin
			if (shadow_keys[idx[IDX_W-1:0]] == target) begin
				hit = idx;
				return 1;
			end
			idx = (idx + stride) % n;
		end
		return 0;
	endfunction

	function automatic dht_out_t predict_lookup(input dht_in_t req);
		dht_out_t    res;
		logic [63:0] k;
		int unsigned sum;
		int unsigned n;
		int unsigned hit;
		res = '0;
		k   = trim_key(req.key, sum);
		n   = 32'(shadow_size);
		if (n < SIZE_MIN) n = SIZE_MIN;
		if (n > DEPTH) n = DEPTH;
		if (k == 64'd0) begin
			res.status = ST_EMPTY_KEY;
		end else if (req.opcode == OP_INSERT) begin
			if (walk_probe(64'd0, sum, n, hit)) begin
				shadow_keys[hit[IDX_W-1:0]] = k;
				shadow_vals[hit[IDX_W-1:0]] = req.value;
				res.status = ST_INSERTED;
				res.slot   = hit[9:0];
				live_keys.push_back(k);
			end else begin
				res.status = ST_FULL;
			end
		end else if (walk_probe(k, sum, n, hit)) begin
			res.status      = ST_FOUND;
			res.slot        = hit[9:0];
			res.found_value = shadow_vals[hit[IDX_W-1:0]];
		end else begin
			res.status = ST_NOT_FOUND;
		end
		return res;
	endfunction

	// Setup then access phase; the register takes the value on the access edge.
	task automatic write_size(input logic [CFG_W-1:0] size);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TABLE_SIZE;
		pwdata  <= {21'd0, size};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow_size = size;
	endtask

	// Send one transaction; the prediction is queued when it is accepted.
	task automatic send_item(input dht_in_t req, input bit check_fixed, input dht_out_t fixed);
		dht_out_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			@(posedge clk);
			in_valid <= 1'b0;
		end
		@(posedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// Accepted at this edge; the predictor tracks state in accept order.
		want = predict_lookup(req);
		if (check_fixed && want !== fixed)
			report_mismatch("table row disagrees with prediction", longint'(fixed),
				longint'(want));
		pending_results.push_back(want);
		in_valid <= 1'b0;
	endtask

	// Wait for every result, then let the block settle before a register write.
	task automatic drain;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [63:0] random_key();
		logic [63:0] k;
		int          len;
		k = {$urandom, $urandom};
		case ($urandom_range(3))
			0: begin
				len = $urandom_range(1, 8);
				for (int p = 0; p < 8; p++)
					if (p < len && k[8*p +: 8] == 8'd0) k[8*p +: 8] = 8'd1;
			end
			1: k = {56'd0, 8'($urandom_range(1, 255))};
			default: ;
		endcase
		return k;
	endfunction

	function automatic dht_in_t random_item();
		dht_in_t req;
		req.opcode = 1'($urandom_range(1));
		req.value  = $urandom;
		if (req.opcode == OP_FIND && live_keys.size() != 0 && $urandom_range(2) != 0) begin
			req.key = live_keys[$urandom_range(live_keys.size() - 1)];
			// Garbage after a zero byte must not change the lookup.
			if (req.key[63:56] == 8'd0 && $urandom_range(1)) begin
				for (int p = 7; p > 0; p--)
					if (req.key[8*p +: 8] == 8'd0 && req.key[8*(p-1) +: 8] == 8'd0)
						req.key[8*p +: 8] = 8'($urandom);
			end
		end else begin
			req.key = random_key();
		end
		return req;
	endfunction

	typedef struct {
		dht_in_t  req;
		bit       fixed;
		dht_out_t want;
	} stim_row_t;

	stim_row_t directed [$];

	function automatic stim_row_t row(input logic op, input logic [63:0] k, input logic [31:0] v,
			input bit fixed, input logic [2:0] st, input logic [9:0] sl, input logic [31:0] fv);
		stim_row_t r;
		r.req.opcode = op;
		r.req.key    = k;
		r.req.value  = v;
		r.fixed      = fixed;
		r.want.status      = st;
		r.want.slot        = sl;
		r.want.found_value = fv;
		return r;
	endfunction

	initial begin
		dht_in_t  req;
		dht_out_t none;
		int       sizes [6];
		none          = '0;
		errors        = 0;
		cycles        = 0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_stall     = 1'b0;
		send_idle_pct = 16;
		recv_idle_pct = 46;
		shadow_size   = SIZE_RESET;
		for (int i = 0; i < DEPTH; i++) begin
			shadow_keys[i[IDX_W-1:0]] = '0;
			shadow_vals[i[IDX_W-1:0]] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows at the reset size 1021. A one-byte key 'A' sums to 65.
		directed.push_back(row(OP_FIND, 64'h41, 0, 1, ST_NOT_FOUND, 0, 0));
		directed.push_back(row(OP_INSERT, 64'h41, 32'hFFFF_FFFF, 1, ST_INSERTED, 65, 0));
		directed.push_back(row(OP_FIND, 64'h41, 32'h1234, 1, ST_FOUND, 65, 32'hFFFF_FFFF));
		// Same key again takes the next slot on the path: 65 + 66.
		directed.push_back(row(OP_INSERT, 64'h41, 32'h0, 1, ST_INSERTED, 131, 0));
		directed.push_back(row(OP_FIND, 64'hDEAD_BEEF_0000_0041, 0, 1, ST_FOUND, 65,
			32'hFFFF_FFFF));
		directed.push_back(row(OP_INSERT, 64'h0, 32'h5, 1, ST_EMPTY_KEY, 0, 0));
		directed.push_back(row(OP_FIND, 64'hFFFF_FFFF_FFFF_FF00, 0, 1, ST_EMPTY_KEY, 0, 0));
		directed.push_back(row(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A, 0, 0, 0, 0));
		directed.push_back(row(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_INSERT, 64'h0101_0101_0101_0101, 32'h1, 0, 0, 0, 0));
		directed.push_back(row(OP_FIND, 64'h0101_0101_0101_0101, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_FIND, 64'h0000_0000_0101_0101, 0, 0, 0, 0, 0));
		foreach (directed[i]) send_item(directed[i].req, directed[i].fixed, directed[i].want);
		drain();

		// Smallest table: five inserts fill it, the sixth reports it full.
		write_size(11'd5);
		for (int i = 0; i < 6; i++) begin
			req.opcode = OP_INSERT;
			req.key    = 64'h42 + i;
			req.value  = $urandom;
			send_item(req, 0, none);
		end
		req.opcode = OP_INSERT;
		req.key    = 64'h7A;
		send_item(req, 1, '{status: ST_FULL, slot: 0, found_value: 0});
		req.opcode = OP_FIND;
		req.key    = 64'h7A7A;
		send_item(req, 1, '{status: ST_NOT_FOUND, slot: 0, found_value: 0});
		drain();
		// Below the minimum, the block still uses five slots.
		write_size(11'd0);
		req.opcode = OP_FIND;
		req.key    = 64'h43;
		send_item(req, 0, none);
		drain();

		// Random phases over several sizes, including clamped extremes.
		sizes = '{2047, 1024, 7, 31, 200, 1021};
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 46;
				recv_idle_pct = 16;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_size(CFG_W'(sizes[ph]));
			for (int i = 0; i < 158; i++) send_item(random_item(), 0, none);
			drain();
		end

		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

FILE: double_hash_table.f
hdl/dht_pkg.sv
hdl/dht_fifo.sv
hdl/dht_front.sv
hdl/dht_back.sv
hdl/double_hash_table.sv
sim/testbench.sv
